// ===== sv/fermat_primality_test_top_assert.svh =====
// Assertion macros for the Fermat test block. Each check is clocked on clk and
// is switched off while arst_n is low.
`ifndef FERMAT_PRIMALITY_TEST_TOP_ASSERT_SVH
`define FERMAT_PRIMALITY_TEST_TOP_ASSERT_SVH
`ifndef SYNTH
// A property that must hold at every clock edge out of reset.
`define FPT_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("fermat_primality_test_top: assertion failed");
// An implication from a condition to a consequence in the same cycle.
`define FPT_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fermat_primality_test_top: implication failed");
`else
`define FPT_ASSERT(lbl, prop)
`define FPT_ASSERT_IMPL(lbl, ante, cons)
`endif
`endif

// ===== sv/fpt_pkg.sv =====
package fpt_pkg;

	// Default width of the candidate as read by the datapath.
	localparam int VALUE_WIDTH_DEF = 32;

	// Width of the raw random word, and of the shared step counter.
	localparam int RANDOM_W = 31;
	localparam int CNT_W    = 5;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_LOAD,
		ST_EXP,
		ST_FIN
	} fpt_state_t;

endpackage

// ===== sv/fermat_primality_test_top.sv =====
// Fermat probable-prime test, one round per request.
// Input channel (cand_valid / cand_ready) carries the candidate, a raw random
// word and a last-round mark. Output channel (verdict_valid / verdict_ready)
// carries one verdict bit, sent only for a request marked as the last round.
// A round takes one request at a time. The base is formed by a restoring
// divider that consumes one random bit per cycle, then a load state. The
// power is found by right-to-left square-and-multiply: for each of the L
// bits of n-1, a square and a multiply run side by side, both as
// interleaved modular multiplies that take one multiplier bit per cycle.
// A final state settles the verdict. A candidate of one or less, or with
// its top bit set, skips the divider and goes straight to the final state.
// The verdict sits in an output register; cand_ready rises again as soon as
// the round is done, so a new request is taken while a verdict waits. Only a
// second verdict that finds the register still full waits for the receiver.
// Reset clears the sequencer and the verdict valid flag and sets the sticky
// passing flag.
`include "fermat_primality_test_top_assert.svh"

module fermat_primality_test_top #(
	parameter int VALUE_WIDTH = fpt_pkg::VALUE_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cand_valid,
	output logic                         cand_ready,
	input  logic signed [31:0]           candidate,
	input  logic [fpt_pkg::RANDOM_W-1:0] random_word,
	input  logic                         last_round,
	output logic                         verdict_valid,
	input  logic                         verdict_ready,
	output logic                         is_probable_prime
);

	localparam int W  = VALUE_WIDTH;
	localparam int NW = VALUE_WIDTH - 1;
	localparam int RW = fpt_pkg::RANDOM_W;
	localparam int CW = fpt_pkg::CNT_W;

	// One step of an interleaved modular multiply: r = 2r + (b ? a : 0) mod n.
	function automatic logic [NW-1:0] mod_step(
		input logic [NW-1:0] r,
		input logic [NW-1:0] a,
		input logic          b,
		input logic [NW-1:0] n
	);
		logic [W:0] t;
		logic [W:0] n1;
		logic [W:0] n2;
		logic [W:0] res;
		t  = {1'b0, r, 1'b0} + (b ? {2'b00, a} : {(W+1){1'b0}});
		n1 = {2'b00, n};
		n2 = {1'b0, n, 1'b0};
		if (t >= n2) begin
			res = t - n2;
		end else if (t >= n1) begin
			res = t - n1;
		end else begin
			res = t;
		end
		return res[NW-1:0];
	endfunction

	fpt_pkg::fpt_state_t state_q, state_d;

	logic [NW-1:0] n_q;
	logic [NW-1:0] e_q;
	logic [RW-1:0] rnd_q;
	logic [NW-1:0] rem_q;
	logic [NW-1:0] base_q;
	logic [NW-1:0] acc_q;
	logic [NW-1:0] m_q;
	logic [NW-1:0] rsq_q;
	logic [NW-1:0] racc_q;
	logic [CW-1:0] cnt_q;
	logic          last_q;
	logic          bad_q;
	logic          still_q;
	logic          vout_q;
	logic          verdict_q;

	// Candidate decode at the input.
	logic [W-1:0]  raw;
	logic          raw_bad;
	assign raw     = candidate[W-1:0];
	assign raw_bad = raw[W-1] || (raw[NW-1:0] <= NW'(1));

	// Divider step: shift in one random bit, subtract n-1 when it fits.
	logic [W-1:0]  div_t;
	logic          div_ge;
	logic [NW-1:0] rem_d;
	logic [W-1:0]  div_diff;
	assign div_t    = {rem_q, rnd_q[RW-1]};
	assign div_ge   = div_t >= {1'b0, e_q};
	assign div_diff = div_t - {1'b0, e_q};
	assign rem_d    = div_ge ? div_diff[NW-1:0] : div_t[NW-1:0];

	// Square and multiply units share the multiplier bit stream of the base.
	logic [NW-1:0] rsq_d;
	logic [NW-1:0] racc_d;
	assign rsq_d  = mod_step(rsq_q, base_q, m_q[NW-1], n_q);
	assign racc_d = mod_step(racc_q, acc_q, m_q[NW-1], n_q);

	// Step counter end points and round outcome.
	logic div_last;
	logic mul_last;
	logic exp_done;
	logic round_pass;
	logic slot_free;
	assign div_last   = cnt_q == CW'(RW - 1);
	assign mul_last   = cnt_q == CW'(NW - 1);
	assign exp_done   = e_q[NW-1:1] == '0;
	assign round_pass = !bad_q && (acc_q == NW'(1));
	assign slot_free  = !vout_q || verdict_ready;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fpt_pkg::ST_IDLE: begin
				if (cand_valid) begin
					state_d = raw_bad ? fpt_pkg::ST_FIN : fpt_pkg::ST_DIV;
				end
			end
			fpt_pkg::ST_DIV: begin
				if (div_last) begin
					state_d = fpt_pkg::ST_LOAD;
				end
			end
			fpt_pkg::ST_LOAD: begin
				state_d = fpt_pkg::ST_EXP;
			end
			fpt_pkg::ST_EXP: begin
				if (mul_last && exp_done) begin
					state_d = fpt_pkg::ST_FIN;
				end
			end
			fpt_pkg::ST_FIN: begin
				if (!last_q || slot_free) begin
					state_d = fpt_pkg::ST_IDLE;
				end
			end
			default: state_d = fpt_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	logic fin_go;
	logic emit;
	always_comb begin
		cand_ready = 1'b0;
		fin_go     = 1'b0;
		unique case (state_q)
			fpt_pkg::ST_IDLE: cand_ready = 1'b1;
			fpt_pkg::ST_FIN:  fin_go     = !last_q || slot_free;
			default: begin
				cand_ready = 1'b0;
				fin_go     = 1'b0;
			end
		endcase
	end
	assign emit = fin_go && last_q;

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fpt_pkg::ST_IDLE;
			cnt_q   <= '0;
			still_q <= 1'b1;
			vout_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == fpt_pkg::ST_DIV || state_q == fpt_pkg::ST_EXP) begin
				cnt_q <= (state_q == fpt_pkg::ST_EXP && mul_last) ? '0 : cnt_q + CW'(1);
			end else begin
				cnt_q <= '0;
			end
			if (fin_go) begin
				still_q <= last_q ? 1'b1 : (still_q && round_pass);
			end
			if (emit) begin
				vout_q <= 1'b1;
			end else if (verdict_ready) begin
				vout_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			fpt_pkg::ST_IDLE: begin
				if (cand_valid) begin
					n_q    <= raw[NW-1:0];
					e_q    <= raw[NW-1:0] - NW'(1);
					rnd_q  <= random_word;
					rem_q  <= '0;
					last_q <= last_round;
					bad_q  <= raw_bad;
				end
			end
			fpt_pkg::ST_DIV: begin
				rem_q <= rem_d;
				rnd_q <= {rnd_q[RW-2:0], 1'b0};
			end
			fpt_pkg::ST_LOAD: begin
				base_q <= rem_q + NW'(1);
				m_q    <= rem_q + NW'(1);
				acc_q  <= NW'(1);
				rsq_q  <= '0;
				racc_q <= '0;
			end
			fpt_pkg::ST_EXP: begin
				if (mul_last) begin
					base_q <= rsq_d;
					m_q    <= rsq_d;
					if (e_q[0]) begin
						acc_q <= racc_d;
					end
					e_q    <= e_q >> 1;
					rsq_q  <= '0;
					racc_q <= '0;
				end else begin
					rsq_q  <= rsq_d;
					racc_q <= racc_d;
					m_q    <= {m_q[NW-2:0], 1'b0};
				end
			end
			fpt_pkg::ST_FIN: begin
				if (emit) begin
					verdict_q <= still_q && round_pass;
				end
			end
			default: begin
			end
		endcase
	end

	assign verdict_valid     = vout_q;
	assign is_probable_prime = verdict_q;

	// The divider remainder stays below the divisor n-1.
	`FPT_ASSERT_IMPL(a_div_rem, state_q == fpt_pkg::ST_DIV, rem_q < e_q)
	// Base and accumulator stay reduced modulo n while exponentiating.
	`FPT_ASSERT_IMPL(a_exp_reduced, state_q == fpt_pkg::ST_EXP,
		(base_q < n_q) && (acc_q < n_q))
	// The exponent still has bits left while exponentiating.
	`FPT_ASSERT_IMPL(a_exp_live, state_q == fpt_pkg::ST_EXP, e_q != '0)
	// A verdict appears only from the final state of a last round.
	`FPT_ASSERT(a_verdict_src,
		$rose(vout_q) |-> ($past(state_q) == fpt_pkg::ST_FIN && $past(last_q)))

endmodule

// ===== verif/fermat_primality_test_top_tb.sv =====
`timescale 1ns / 100ps

module fermat_primality_test_top_tb;

	localparam int VW             = fpt_pkg::VALUE_WIDTH_DEF;
	localparam int TOTAL_ROUNDS   = 290;
	localparam int WATCHDOG_LIMIT = 6000;
	localparam int DRAIN_CYCLES   = 64;
	localparam int MAX_REPORTS    = 10;
	localparam logic [fpt_pkg::RANDOM_W-1:0] RND_MAX = '1;

	// One Fermat round as it sits in the send queue, with the idle gap before it.
	typedef struct {
		logic signed [31:0]           cand;
		logic [fpt_pkg::RANDOM_W-1:0] rnd;
		logic                         last;
		int                           gap;
	} round_req_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         cand_valid = 1'b0;
	logic                         cand_ready;
	logic signed [31:0]           candidate = '0;
	logic [fpt_pkg::RANDOM_W-1:0] random_word = '0;
	logic                         last_round = 1'b0;
	logic                         verdict_valid;
	logic                         verdict_ready = 1'b0;
	logic                         is_probable_prime;

	round_req_t requests_pending[$];
	bit         verdicts_due[$];
	bit         sticky_pass = 1'b1;
	int         send_gap = 0;
	int         recv_gap = 0;
	bit         recv_calm = 1'b0;
	int         verdicts_seen = 0;
	int         error_count = 0;
	int         idle_cycles = 0;

	fermat_primality_test_top DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.cand_valid       (cand_valid),
		.cand_ready       (cand_ready),
		.candidate        (candidate),
		.random_word      (random_word),
		.last_round       (last_round),
		.verdict_valid    (verdict_valid),
		.verdict_ready    (verdict_ready),
		.is_probable_prime(is_probable_prime)
	);

	// Free-running clock with an 8 ns period.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// True when base^(n-1) mod n is 1 for the base that this random word selects.
	function automatic bit round_passes(logic signed [31:0] cand,
			logic [fpt_pkg::RANDOM_W-1:0] rnd);
		bit [63:0] n;
		bit [63:0] base;
		bit [63:0] pow;
		bit [63:0] acc;
		n = 64'(cand) & ((64'd1 << VW) - 64'd1);
		if (n[VW-1] || n <= 64'd1) return 1'b0;
		base = (64'(rnd) % (n - 64'd1)) + 64'd1;
		pow = n - 64'd1;
		acc = 64'd1;
		while (pow != 64'd0) begin
			if (pow[0]) acc = (acc * base) % n;
			base = (base * base) % n;
			pow = pow >> 1;
		end
		return acc == 64'd1;
	endfunction

	// Fold one accepted round into the sticky flag and queue a verdict on the last one.
	task automatic track_verdict(round_req_t req);
		if (!round_passes(req.cand, req.rnd)) sticky_pass = 1'b0;
		if (req.last) begin
			verdicts_due.push_back(sticky_pass);
			sticky_pass = 1'b1;
		end
	endtask

	task automatic add_req(logic signed [31:0] cand, logic [fpt_pkg::RANDOM_W-1:0] rnd,
			logic last, int gap);
		round_req_t req;
		req.cand = cand;
		req.rnd = rnd;
		req.last = last;
		req.gap = gap;
		requests_pending.push_back(req);
	endtask

	// Known primes, pseudoprimes and Carmichael numbers.
	function automatic logic signed [31:0] pick_listed(bit want_prime);
		if (want_prime) begin
			case ($urandom_range(0, 13))
				0:  return 2;
				1:  return 3;
				2:  return 5;
				3:  return 7;
				4:  return 13;
				5:  return 97;
				6:  return 7919;
				7:  return 65521;
				8:  return 65537;
				9:  return 104729;
				10: return 1000003;
				11: return 999999937;
				12: return 1073741789;
				default: return 2147483647;
			endcase
		end
		case ($urandom_range(0, 10))
			0:  return 341;
			1:  return 561;
			2:  return 1105;
			3:  return 1729;
			4:  return 2465;
			5:  return 2821;
			6:  return 6601;
			7:  return 8911;
			8:  return 41041;
			9:  return 825265;
			default: return 321197185;
		endcase
	endfunction

	function automatic logic signed [31:0] pick_candidate();
		int          r;
		int          nbits;
		logic [31:0] v;
		r = $urandom_range(0, 99);
		nbits = $urandom_range(2, 31);
		v = $urandom & ((32'd1 << nbits) - 32'd1);
		v[nbits-1] = 1'b1;
		if (r < 35) return pick_listed(1'b1);
		if (r < 50) return pick_listed(1'b0);
		if (r < 75) return signed'(v | 32'd1);
		if (r < 85) return $urandom_range(0, 20);
		if (r < 95) return signed'(32'($urandom));
		return signed'(v & ~32'd1);
	endfunction

	function automatic logic [fpt_pkg::RANDOM_W-1:0] pick_random_word();
		int          r;
		logic [31:0] w;
		r = $urandom_range(0, 9);
		w = $urandom;
		if (r == 0) return '0;
		if (r == 1) return RND_MAX;
		return w[fpt_pkg::RANDOM_W-1:0];
	endfunction

	// A run of rounds ending in a last mark; the candidate sometimes changes midway.
	task automatic add_group();
		int                 rounds;
		int                 k;
		bit                 calm;
		logic signed [31:0] cand;
		rounds = $urandom_range(1, 5);
		calm = ($urandom_range(0, 4) == 0);
		cand = pick_candidate();
		for (k = 0; k < rounds; k++) begin
			if ($urandom_range(0, 9) == 0) cand = pick_candidate();
			add_req(cand, pick_random_word(), k == rounds - 1, calm ? 0 : pick_gap());
		end
	endtask

	// Request driver: holds each request until it is taken, then waits out the gap before the next.
	always @(posedge clk or negedge arst_n) begin
		round_req_t req;
		bit         busy;
		if (!arst_n) begin
			cand_valid <= 1'b0;
			send_gap = 0;
		end else begin
			busy = cand_valid;
			if (cand_valid && cand_ready) begin
				req.cand = candidate;
				req.rnd = random_word;
				req.last = last_round;
				req.gap = 0;
				track_verdict(req);
				busy = 1'b0;
			end
			if (!busy) begin
				if (requests_pending.size() != 0 && send_gap == 0) begin
					send_gap = requests_pending[0].gap;
				end
				if (requests_pending.size() == 0) begin
					cand_valid <= 1'b0;
				end else if (send_gap > 0) begin
					send_gap--;
					requests_pending[0].gap = send_gap;
					cand_valid <= 1'b0;
				end else begin
					req = requests_pending.pop_front();
					candidate <= req.cand;
					random_word <= req.rnd;
					last_round <= req.last;
					cand_valid <= 1'b1;
				end
			end
		end
	end

	// Verdict monitor: checks each verdict against the oldest expected one and
	// stalls the receiver at random.
	always @(posedge clk or negedge arst_n) begin
		bit ready_next;
		bit want;
		if (!arst_n) begin
			verdict_ready <= 1'b0;
			recv_gap = 0;
		end else begin
			ready_next = 1'b1;
			if (verdict_valid && verdict_ready) begin
				if (verdicts_due.size() == 0) begin
					error_count++;
					if (error_count <= MAX_REPORTS)
						$display("verdict with none expected: got %0d", is_probable_prime);
				end else begin
					want = verdicts_due.pop_front();
					if (is_probable_prime !== want) begin
						error_count++;
						if (error_count <= MAX_REPORTS)
							$display("verdict mismatch: expected %0d, got %0d",
								want, is_probable_prime);
					end
				end
				verdicts_seen++;
				if (verdicts_seen % 12 == 0) recv_calm = ($urandom_range(0, 3) == 0);
				if (!recv_calm) recv_gap = pick_gap();
			end else if (!verdict_valid && !recv_calm && $urandom_range(0, 49) == 0) begin
				recv_gap = pick_gap();
			end
			if (recv_gap > 0) begin
				recv_gap--;
				ready_next = 1'b0;
			end
			verdict_ready <= ready_next;
		end
	end

	// Watchdog: too many cycles without any handshake ends the run.
	always @(posedge clk) begin
		if ((cand_valid && cand_ready) || (verdict_valid && verdict_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		// Directed rounds: trivial candidates, extremes and sticky failures.
		add_req(0, 0, 1'b1, 0);
		add_req(1, RND_MAX, 1'b1, 0);
		add_req(-1, RND_MAX, 1'b1, pick_gap());
		add_req(32'sh8000_0000, 0, 1'b1, 0);
		add_req(2, 0, 1'b1, 0);
		add_req(2, RND_MAX, 1'b1, pick_gap());
		add_req(3, 0, 1'b1, 0);
		add_req(4, 0, 1'b1, 0);
		add_req(2147483647, RND_MAX, 1'b1, 0);
		add_req(2147483647, 0, 1'b0, pick_gap());
		add_req(2147483646, 12345, 1'b1, 0);
		add_req(561, 1, 1'b0, 0);
		add_req(561, 5, 1'b1, 0);
		add_req(15, 1, 1'b0, pick_gap());
		add_req(13, 7, 1'b0, 0);
		add_req(13, RND_MAX, 1'b1, 0);
		add_req(7, 3, 1'b0, 0);
		add_req(7, 4, 1'b0, 0);
		add_req(7, 5, 1'b1, 0);
		add_req(65537, 12345, 1'b1, pick_gap());
		add_req(2147483645, RND_MAX, 1'b1, 0);
		add_req(32'sh7FFF_FFFE, 31'h5555_5555, 1'b1, 0);
		add_req(32'shAAAA_AAAB, 31'h2AAA_AAAA, 1'b1, 0);

		// Random groups of rounds.
		while (requests_pending.size() < TOTAL_ROUNDS) add_group();

		// Hold reset, then release it.
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for every request to go out and every verdict to come back.
		while (requests_pending.size() != 0 || cand_valid) @(posedge clk);
		while (verdicts_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0 && verdicts_due.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
